/* src/rotated_projection_bin_classifier_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the rotated projection bin classifier
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ROTATED_PROJECTION_BIN_CLASSIFIER_ASSERT_SVH
`define ROTATED_PROJECTION_BIN_CLASSIFIER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPBC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RPBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/rpbc_pkg.sv */
// ----------------------------------------------------------------------------
// rpbc_pkg
// Shared types and constants of the rotated projection bin classifier.
// ----------------------------------------------------------------------------
package rpbc_pkg;

    localparam int NUM_BINS_DEF    = 10;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_COS_COEF  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SIN_COEF  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MIN_X     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BIN_SCALE = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_HARD_MODE = 3'd4;

    localparam logic signed [15:0] COS_COEF_RST = 16'sd32767;

    // Ratio windows, all scaled by RATIO_DEN so the tests stay in integers.
    localparam int RATIO_DEN  = 10;
    localparam int RATIO_HALF = 5;
    localparam int RATIO_HIGH = 18;
    localparam int TOL_TIGHT  = 1;
    localparam int TOL_LOOSE  = 2;

    typedef struct packed {
        logic signed [15:0] cos_coef;
        logic signed [15:0] sin_coef;
        logic signed [31:0] min_x;
        logic        [31:0] bin_scale;
        logic               hard_mode;
    } cfg_t;

    typedef struct packed {
        logic cap;
        logic mul;
        logic off;
        logic scl;
        logic bin;
        logic upd;
        logic fin;
    } dp_cmd_t;

    typedef struct packed {
        logic below;
    } dp_stat_t;

endpackage

/* src/rpbc_cfg.sv */
// ----------------------------------------------------------------------------
// rpbc_cfg
// APB register file holding the rotation, range and mode settings.
// ----------------------------------------------------------------------------
module rpbc_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rpbc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [rpbc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [rpbc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output rpbc_pkg::cfg_t                   cfg
);

    logic [rpbc_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           wr_en;

    logic signed [15:0] cos_coef_reg;
    logic signed [15:0] sin_coef_reg;
    logic signed [31:0] min_x_reg;
    logic        [31:0] bin_scale_reg;
    logic               hard_mode_reg;

    assign pready  = 1'b1;
    assign reg_idx = paddr[rpbc_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_coef_reg  <= rpbc_pkg::COS_COEF_RST;
            sin_coef_reg  <= '0;
            min_x_reg     <= '0;
            bin_scale_reg <= '0;
            hard_mode_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                rpbc_pkg::REG_COS_COEF:  cos_coef_reg  <= $signed(pwdata[15:0]);
                rpbc_pkg::REG_SIN_COEF:  sin_coef_reg  <= $signed(pwdata[15:0]);
                rpbc_pkg::REG_MIN_X:     min_x_reg     <= $signed(pwdata[31:0]);
                rpbc_pkg::REG_BIN_SCALE: bin_scale_reg <= pwdata[31:0];
                rpbc_pkg::REG_HARD_MODE: hard_mode_reg <= pwdata[0];
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            rpbc_pkg::REG_COS_COEF:  prdata = {16'd0, cos_coef_reg};
            rpbc_pkg::REG_SIN_COEF:  prdata = {16'd0, sin_coef_reg};
            rpbc_pkg::REG_MIN_X:     prdata = min_x_reg;
            rpbc_pkg::REG_BIN_SCALE: prdata = bin_scale_reg;
            rpbc_pkg::REG_HARD_MODE: prdata = {31'd0, hard_mode_reg};
            default:                 prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.cos_coef  = cos_coef_reg;
        cfg.sin_coef  = sin_coef_reg;
        cfg.min_x     = min_x_reg;
        cfg.bin_scale = bin_scale_reg;
        cfg.hard_mode = hard_mode_reg;
    end

endmodule

/* src/rpbc_ctrl.sv */
// ----------------------------------------------------------------------------
// rpbc_ctrl
// Sequencer that walks each request through the datapath steps.
// ----------------------------------------------------------------------------
module rpbc_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                kind,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  rpbc_pkg::dp_stat_t  stat,
    output rpbc_pkg::dp_cmd_t   cmd
);

    `include "rotated_projection_bin_classifier_assert.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_OFF  = 3'd2;
    localparam logic [2:0] S_SCL  = 3'd3;
    localparam logic [2:0] S_BIN  = 3'd4;
    localparam logic [2:0] S_UPD  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap    = 1'b1;
                    state_next = kind ? S_FIN : S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_OFF;
            end
            S_OFF:
            begin
                cmd.off    = 1'b1;
                state_next = S_SCL;
            end
            S_SCL:
            begin
                // A point below the range has no bin; go straight to the update.
                cmd.scl    = !stat.below;
                state_next = stat.below ? S_UPD : S_BIN;
            end
            S_BIN:
            begin
                cmd.bin    = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = S_IDLE;
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.fin)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `RPBC_ASSERT_SAME(a_fin_slot_free, cmd.fin, !out_valid_reg || !out_stall, "result loaded over a pending result")
    `RPBC_ASSERT_NEXT(a_point_to_mul, cmd.cap && !kind, state_reg == S_MUL, "point request did not enter the multiply step")
    `RPBC_ASSERT_NEXT(a_upd_to_idle, cmd.upd, state_reg == S_IDLE && !in_stall, "sequencer did not return to idle after update")
    `RPBC_ASSERT_SAME(a_valid_from_fin, $rose(out_valid_reg), $past(cmd.fin), "result valid rose without a finish step")

endmodule

/* src/rpbc_dpath.sv */
// ----------------------------------------------------------------------------
// rpbc_dpath
// Rotation, binning, histogram counters and end-bin ratio decision.
// ----------------------------------------------------------------------------
module rpbc_dpath
#(
    parameter int NUM_BINS    = rpbc_pkg::NUM_BINS_DEF,
    parameter int COUNT_WIDTH = rpbc_pkg::COUNT_WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  rpbc_pkg::cfg_t      cfg,
    input  rpbc_pkg::dp_cmd_t   cmd,
    output rpbc_pkg::dp_stat_t  stat,
    input  logic signed [15:0]  x,
    input  logic signed [15:0]  y,
    output logic                is_match,
    output logic                any_dropped
);

    localparam int BW = $clog2(NUM_BINS);
    localparam int RW = COUNT_WIDTH + 6;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic signed [15:0]      x_reg;
    logic signed [15:0]      y_reg;
    logic signed [31:0]      pc_reg;
    logic signed [31:0]      ps_reg;
    logic signed [33:0]      off_full;
    logic        [32:0]      off_reg;
    logic                    below_reg;
    logic        [63:0]      lo_prod;
    logic        [31:0]      prod_hi_reg;
    logic                    top_reg;
    logic        [32:0]      bin_sum;
    logic        [BW-1:0]    bin_next;
    logic        [BW-1:0]    bin_reg;
    logic [COUNT_WIDTH-1:0]  bin_counts_reg [NUM_BINS];
    logic                    drop_flag_reg;
    logic                    cnt_full;
    logic                    left_half;
    logic                    left_high;
    logic                    right_half_t;
    logic                    right_half_l;
    logic                    right_high_l;
    logic                    match_next;
    logic                    is_match_reg;
    logic                    any_dropped_reg;

    // |10a - target*b| < tol*b with b nonzero.
    function automatic logic near_ratio(input logic [COUNT_WIDTH-1:0] a,
                                        input logic [COUNT_WIDTH-1:0] b,
                                        input int tgt,
                                        input int tol);
        logic signed [RW-1:0] sa;
        logic signed [RW-1:0] sb;
        logic signed [RW-1:0] diff;
        logic signed [RW-1:0] mag;
        logic signed [RW-1:0] lim;
        sa   = $signed(RW'(a));
        sb   = $signed(RW'(b));
        diff = sa * RW'(rpbc_pkg::RATIO_DEN) - sb * RW'(tgt);
        mag  = diff[RW-1] ? -diff : diff;
        lim  = sb * RW'(tol);
        return (b != '0) && (mag < lim);
    endfunction

    assign stat.below = below_reg;

    assign off_full = 34'(pc_reg) - 34'(ps_reg) - 34'(cfg.min_x);
    assign lo_prod  = 64'(off_reg[31:0]) * 64'(cfg.bin_scale);
    assign bin_sum  = (top_reg ? {1'b0, cfg.bin_scale} : 33'd0) + {1'b0, prod_hi_reg};
    assign bin_next = (bin_sum >= 33'(NUM_BINS)) ? BW'(NUM_BINS - 1) : bin_sum[BW-1:0];
    assign cnt_full = (bin_counts_reg[bin_reg] == CNT_MAX);

    assign left_half    = near_ratio(bin_counts_reg[0], bin_counts_reg[1],
                                     rpbc_pkg::RATIO_HALF, rpbc_pkg::TOL_TIGHT);
    assign left_high    = near_ratio(bin_counts_reg[0], bin_counts_reg[1],
                                     rpbc_pkg::RATIO_HIGH, rpbc_pkg::TOL_TIGHT);
    assign right_half_t = near_ratio(bin_counts_reg[NUM_BINS-1], bin_counts_reg[NUM_BINS-2],
                                     rpbc_pkg::RATIO_HALF, rpbc_pkg::TOL_TIGHT);
    assign right_half_l = near_ratio(bin_counts_reg[NUM_BINS-1], bin_counts_reg[NUM_BINS-2],
                                     rpbc_pkg::RATIO_HALF, rpbc_pkg::TOL_LOOSE);
    assign right_high_l = near_ratio(bin_counts_reg[NUM_BINS-1], bin_counts_reg[NUM_BINS-2],
                                     rpbc_pkg::RATIO_HIGH, rpbc_pkg::TOL_LOOSE);

    assign match_next = cfg.hard_mode
                      ? ((left_half && right_high_l) || (left_high && right_half_l))
                      : (left_half || right_half_t);

    // Arithmetic pipeline registers, stepped one at a time by the sequencer.
    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            x_reg <= x;
            y_reg <= y;
        end
        if (cmd.mul)
        begin
            pc_reg <= cfg.cos_coef * x_reg;
            ps_reg <= cfg.sin_coef * y_reg;
        end
        if (cmd.off)
        begin
            off_reg   <= off_full[32:0];
            below_reg <= off_full[33];
        end
        if (cmd.scl)
        begin
            prod_hi_reg <= lo_prod[63:32];
            top_reg     <= off_reg[32];
        end
        if (cmd.bin)
        begin
            bin_reg <= bin_next;
        end
        if (cmd.fin)
        begin
            is_match_reg    <= match_next;
            any_dropped_reg <= drop_flag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BINS; i++)
            begin
                bin_counts_reg[i] <= '0;
            end
            drop_flag_reg <= 1'b0;
        end
        else if (cmd.fin)
        begin
            for (int i = 0; i < NUM_BINS; i++)
            begin
                bin_counts_reg[i] <= '0;
            end
            drop_flag_reg <= 1'b0;
        end
        else if (cmd.upd)
        begin
            if (below_reg || cnt_full)
            begin
                drop_flag_reg <= 1'b1;
            end
            else
            begin
                bin_counts_reg[bin_reg] <= bin_counts_reg[bin_reg] + 1'b1;
            end
        end
    end

    assign is_match    = is_match_reg;
    assign any_dropped = any_dropped_reg;

endmodule

/* src/rotated_projection_bin_classifier.sv */
// ----------------------------------------------------------------------------
// rotated_projection_bin_classifier: histogram of rotated x with end-bin test
// A point request occupies the block through the multiply, offset, scale,
// bin and update steps (no bin step when below range); a finish request
// waits in its finish step while the previous result is still held, and its
// result is valid from the edge that ends that step. One request at a time.
// Reset (async, low) restores register defaults and clears counters and flag.
// ----------------------------------------------------------------------------
module rotated_projection_bin_classifier
#(
    parameter int NUM_BINS    = rpbc_pkg::NUM_BINS_DEF,
    parameter int COUNT_WIDTH = rpbc_pkg::COUNT_WIDTH_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,

    // APB configuration port.
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rpbc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [rpbc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [rpbc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,

    // Request channel: a point or a finish marker.
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             kind,
    input  logic signed [15:0]               x,
    input  logic signed [15:0]               y,

    // Result channel: one decision per finish request.
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             is_match,
    output logic                             any_dropped
);

    // The block is built as three parts. The register file holds the rotation
    // coefficients, range offset, reciprocal span and test mode. The
    // sequencer accepts one request at a time and steps the datapath through
    // its stages with single-bit commands. The datapath holds the arithmetic
    // registers, the histogram counters and the output result register.
    //
    // For a point, the datapath first forms cos*x and sin*y, then the offset
    // of the rotated x from the lower range edge. A negative offset drops the
    // point and sets the drop flag. Otherwise the offset is scaled by the
    // reciprocal span with a 32 by 32 multiply, the top word gives the bin,
    // and a bin at or past the top edge is clamped into the last slot. The
    // selected counter increments unless already full, in which case the
    // drop flag is set instead.
    //
    // For a finish request, the end-bin ratios are tested by
    // cross-multiplication against the windows around one half and 1.8, the
    // decision and drop flag go to the output register, and the histogram and
    // flag are cleared. The sequencer waits for the output register to be
    // free before loading it, so a result waiting downstream holds up a second
    // finish request and all requests after it, but not the points before it.

    rpbc_pkg::cfg_t     cfg;
    rpbc_pkg::dp_cmd_t  cmd;
    rpbc_pkg::dp_stat_t stat;

    rpbc_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rpbc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .kind      (kind),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    rpbc_dpath
    #(
        .NUM_BINS    (NUM_BINS),
        .COUNT_WIDTH (COUNT_WIDTH)
    )
    u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .stat        (stat),
        .x           (x),
        .y           (y),
        .is_match    (is_match),
        .any_dropped (any_dropped)
    );

endmodule

/* verif/rotated_projection_bin_classifier_test.sv */
// ----------------------------------------------------------------------------
// rotated_projection_bin_classifier_test
// Self-checking bench for the rotated projection bin classifier. Point and
// finish requests are driven through the valid/stall channel while a local
// histogram predictor works out every decision. Each decision the block
// returns is compared field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module rotated_projection_bin_classifier_test;

    localparam int NB         = rpbc_pkg::NUM_BINS_DEF;
    localparam int CW         = rpbc_pkg::COUNT_WIDTH_DEF;
    localparam bit KIND_POINT  = 1'b0;
    localparam bit KIND_FINISH = 1'b1;

    // A point request keeps the block busy only through its datapath steps, so
    // the settle wait after the last decision covers any point still in flight.
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 400;

    typedef struct {
        bit is_match;
        bit any_dropped;
    } decision_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [rpbc_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [rpbc_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [rpbc_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  kind = 1'b0;
    logic signed [15:0]    x = '0;
    logic signed [15:0]    y = '0;

    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  is_match;
    logic                  any_dropped;

    // Predictor state: a shadow of the registers, the histogram and the flag.
    rpbc_pkg::cfg_t model_cfg;
    logic [CW-1:0]  hist_count [NB];
    bit             drop_pending;
    decision_t      pending_decisions [$];

    // Idle control and bookkeeping.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int error_count = 0;
    int points_sent = 0;
    int finishes_sent = 0;
    int decisions_checked = 0;
    int matches_seen = 0;
    int drops_seen = 0;

    rotated_projection_bin_classifier u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .x           (x),
        .y           (y),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .is_match    (is_match),
        .any_dropped (any_dropped)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Histogram predictor.
    // ------------------------------------------------------------------------

    // Bin that a point falls into under the shadow registers, or -1 when the
    // rotated x lies below the range. The offset is split into its upper and
    // lower 32-bit halves so that the product never overflows 64 bits.
    function automatic int bin_of(logic signed [15:0] px, logic signed [15:0] py);
        longint          rot_x;
        longint          offs;
        longint unsigned uoff;
        longint unsigned scale;
        longint unsigned idx;
        rot_x = longint'($signed(model_cfg.cos_coef)) * longint'(px)
              - longint'($signed(model_cfg.sin_coef)) * longint'(py);
        offs  = rot_x - longint'($signed(model_cfg.min_x));
        if (offs < 0)
            return -1;
        uoff  = offs;
        scale = longint'(model_cfg.bin_scale);
        idx   = (uoff >> 32) * scale + (((uoff & 64'hFFFF_FFFF) * scale) >> 32);
        if (idx >= NB)
            return NB - 1;
        return int'(idx);
    endfunction

    // True when num/den lies strictly inside target/10 +- tol/10. A zero
    // denominator never passes, which stands in for the division by zero.
    function automatic bit ratio_near(longint num, longint den, longint target, longint tol);
        longint diff;
        if (den == 0)
            return 1'b0;
        diff = rpbc_pkg::RATIO_DEN * num - target * den;
        if (diff < 0)
            diff = -diff;
        return diff < tol * den;
    endfunction

    function automatic void clear_histogram();
        foreach (hist_count[i])
            hist_count[i] = '0;
        drop_pending = 1'b0;
    endfunction

    // Apply one accepted request to the predictor. A finish request queues
    // the decision that the block must return and then empties the set.
    function automatic void predict_request(bit k, logic signed [15:0] px,
                                            logic signed [15:0] py);
        int        b;
        bit        left_half;
        bit        left_high;
        decision_t d;
        if (k == KIND_POINT) begin
            b = bin_of(px, py);
            if (b < 0)
                drop_pending = 1'b1;
            else if (hist_count[b] == {CW{1'b1}})
                drop_pending = 1'b1;
            else
                hist_count[b] = hist_count[b] + 1'b1;
        end
        else begin
            left_half = ratio_near(hist_count[0], hist_count[1],
                                   rpbc_pkg::RATIO_HALF, rpbc_pkg::TOL_TIGHT);
            left_high = ratio_near(hist_count[0], hist_count[1],
                                   rpbc_pkg::RATIO_HIGH, rpbc_pkg::TOL_TIGHT);
            if (model_cfg.hard_mode)
                d.is_match = (left_half && ratio_near(hist_count[NB-1], hist_count[NB-2],
                                                      rpbc_pkg::RATIO_HIGH,
                                                      rpbc_pkg::TOL_LOOSE))
                          || (left_high && ratio_near(hist_count[NB-1], hist_count[NB-2],
                                                      rpbc_pkg::RATIO_HALF,
                                                      rpbc_pkg::TOL_LOOSE));
            else
                d.is_match = left_half || ratio_near(hist_count[NB-1], hist_count[NB-2],
                                                     rpbc_pkg::RATIO_HALF,
                                                     rpbc_pkg::TOL_TIGHT);
            d.any_dropped = drop_pending;
            pending_decisions = {pending_decisions, d};
            clear_histogram();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random stall, with an optional long hold-off counted here.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_cycles = HOLD_CYCLES;
        end
        if (hold_cycles > 0) begin
            out_stall <= 1'b1;
            hold_cycles = hold_cycles - 1;
        end
        else begin
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Every accepted decision is matched against the oldest prediction.
    always @(posedge clk) begin
        decision_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_decisions.size() == 0) begin
                $error("decision returned with none pending: is_match=%0b any_dropped=%0b",
                       is_match, any_dropped);
                error_count++;
            end
            else begin
                want = pending_decisions.pop_front();
                decisions_checked++;
                if (is_match)
                    matches_seen++;
                if (any_dropped)
                    drops_seen++;
                if (is_match !== want.is_match) begin
                    $error("is_match mismatch: expected %0b, actual %0b",
                           want.is_match, is_match);
                    error_count++;
                end
                if (any_dropped !== want.any_dropped) begin
                    $error("any_dropped mismatch: expected %0b, actual %0b",
                           want.any_dropped, any_dropped);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers.
    // ------------------------------------------------------------------------

    // Offer one request, after a random idle gap, and hold it until the block
    // takes it. The predictor is updated at the accepting edge, so it sees
    // requests in exactly the order the block does.
    task automatic send_request(bit k, logic signed [15:0] px, logic signed [15:0] py);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        x        <= px;
        y        <= py;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_request(k, px, py);
        if (k == KIND_POINT)
            points_sent++;
        else
            finishes_sent++;
    endtask

    // APB write: setup cycle, then access cycle until pready. The shadow
    // registers take the value once the access completes, and the bus rests
    // idle before the next transfer.
    task automatic write_register(logic [rpbc_pkg::REG_IDX_W-1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            rpbc_pkg::REG_COS_COEF:  model_cfg.cos_coef  = value[15:0];
            rpbc_pkg::REG_SIN_COEF:  model_cfg.sin_coef  = value[15:0];
            rpbc_pkg::REG_MIN_X:     model_cfg.min_x     = value;
            rpbc_pkg::REG_BIN_SCALE: model_cfg.bin_scale = value;
            rpbc_pkg::REG_HARD_MODE: model_cfg.hard_mode = value[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic program_config(rpbc_pkg::cfg_t c);
        write_register(rpbc_pkg::REG_COS_COEF, 32'(c.cos_coef));
        write_register(rpbc_pkg::REG_SIN_COEF, 32'(c.sin_coef));
        write_register(rpbc_pkg::REG_MIN_X, c.min_x);
        write_register(rpbc_pkg::REG_BIN_SCALE, c.bin_scale);
        write_register(rpbc_pkg::REG_HARD_MODE, 32'(c.hard_mode));
    endtask

    // Stop offering, wait for every pending decision, then let any point
    // still being binned finish before the block counts as idle.
    task automatic wait_for_idle();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_decisions.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (pending_decisions.size() != 0) begin
            $error("%0d decisions never returned", pending_decisions.size());
            error_count++;
            pending_decisions.delete();
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic logic signed [15:0] pick_coef();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Most settings spread the reachable rotated x over all ten bins so that
    // shaped sets can land points where they want; some are fully random.
    function automatic rpbc_pkg::cfg_t spread_config();
        rpbc_pkg::cfg_t  c;
        longint          reach;
        longint          base;
        longint          ca;
        longint          sa;
        longint unsigned scale;
        c.cos_coef  = pick_coef();
        c.sin_coef  = pick_coef();
        c.hard_mode = 1'($urandom_range(0, 1));
        ca = $signed(c.cos_coef);
        sa = $signed(c.sin_coef);
        if (ca < 0)
            ca = -ca;
        if (sa < 0)
            sa = -sa;
        reach = (ca + sa) * 32768;
        if (reach == 0)
            reach = 1;
        base = -reach + longint'($urandom_range(0, 32'(reach / 8)));
        if ($urandom_range(0, 1))
            base = base - longint'($urandom_range(0, 32'(reach / 8)));
        if (base < -(64'sd1 <<< 31))
            base = -(64'sd1 <<< 31);
        c.min_x = base[31:0];
        scale = (64'd10 << 32) / longint'(2 * reach);
        c.bin_scale = (scale > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : scale[31:0];
        if ($urandom_range(0, 4) == 0) begin
            c.min_x     = $urandom;
            c.bin_scale = $urandom;
        end
        return c;
    endfunction

    // Search for a point that lands in the given bin (-1 for below range).
    // If none turns up, the last candidate is used; the predictor still
    // knows exactly where it goes.
    function automatic void find_point(int target, output logic signed [15:0] px,
                                       output logic signed [15:0] py);
        px = 16'($urandom);
        py = 16'($urandom);
        for (int t = 0; t < 400 && bin_of(px, py) != target; t++) begin
            px = 16'($urandom);
            py = 16'($urandom);
        end
    endfunction

    // Queue the points for one end of the histogram, with the numerator
    // count close to half or to 1.8 times the denominator count so that the
    // window edges are hit from both sides.
    function automatic void plan_ratio_pair(ref int plan[$], input int num_bin,
                                            input int den_bin);
        int target;
        int den;
        int num;
        target = $urandom_range(0, 1) ? rpbc_pkg::RATIO_HALF : rpbc_pkg::RATIO_HIGH;
        den    = $urandom_range(0, 7);
        num    = (target * den + rpbc_pkg::RATIO_HALF) / rpbc_pkg::RATIO_DEN
               + $urandom_range(0, 4) - 2;
        if (num < 0)
            num = 0;
        repeat (num)
            plan = {plan, num_bin};
        repeat (den)
            plan = {plan, den_bin};
    endfunction

    // A well-formed set: end-bin counts shaped around the ratio windows, a
    // few middle points, sometimes a point below range, then a finish.
    task automatic send_shaped_set();
        int                 plan [$];
        int                 ends;
        int                 j;
        int                 tmp;
        logic signed [15:0] px;
        logic signed [15:0] py;
        ends = $urandom_range(0, 3);
        if (ends != 1)
            plan_ratio_pair(plan, 0, 1);
        if (ends != 0)
            plan_ratio_pair(plan, NB - 1, NB - 2);
        repeat ($urandom_range(0, 4))
            plan = {plan, int'($urandom_range(2, NB - 3))};
        if ($urandom_range(0, 7) == 0)
            plan = {plan, -1};
        for (int i = plan.size() - 1; i > 0; i--) begin
            j       = $urandom_range(0, i);
            tmp     = plan[i];
            plan[i] = plan[j];
            plan[j] = tmp;
        end
        foreach (plan[i]) begin
            find_point(plan[i], px, py);
            send_request(KIND_POINT, px, py);
        end
        send_request(KIND_FINISH, 16'($urandom), 16'($urandom));
    endtask

    // Noise: random points with occasional extreme coordinates.
    task automatic send_noise_set(int max_points);
        logic signed [15:0] px;
        logic signed [15:0] py;
        repeat ($urandom_range(0, max_points)) begin
            px = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 1) ? 16'h8000 : 16'h7FFF)
                                             : 16'($urandom);
            py = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 1) ? 16'h8000 : 16'h7FFF)
                                             : 16'($urandom);
            send_request(KIND_POINT, px, py);
        end
        send_request(KIND_FINISH, 16'($urandom), 16'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Hand-picked requests at reset settings and at a setting where the bin
    // is simply floor(x * 10 / 256): cos 0.5 makes rx = x << 14, and the
    // scale 10 * 2^32 / 2^22 maps x = 0..256 onto the ten bins.
    task automatic test_directed_cases();
        // Empty set: both denominators are zero.
        send_request(KIND_FINISH, 16'sh0000, 16'sh0000);
        // Reset scale is zero, so everything in range goes to bin 0.
        send_request(KIND_POINT, 16'sh0000, 16'sh8000);
        send_request(KIND_POINT, 16'sh8000, 16'sh7FFF);
        send_request(KIND_POINT, 16'sh7FFF, 16'sh0000);
        send_request(KIND_FINISH, 16'sh7FFF, 16'sh8000);
        wait_for_idle();

        write_register(rpbc_pkg::REG_COS_COEF, 32'd16384);
        write_register(rpbc_pkg::REG_SIN_COEF, 32'd0);
        write_register(rpbc_pkg::REG_MIN_X, 32'd0);
        write_register(rpbc_pkg::REG_BIN_SCALE, 32'd10240);
        // Exactly at the top edge, then clearly above it: both clamp to bin 9.
        send_request(KIND_POINT, 16'sd256, 16'sh7FFF);
        send_request(KIND_POINT, 16'sd32767, 16'sh8000);
        // One point in bin 0 and two in bin 1 gives a left ratio of 0.5.
        send_request(KIND_POINT, 16'sd0, 16'sd5);
        send_request(KIND_POINT, 16'sd26, -16'sd9);
        send_request(KIND_POINT, 16'sd30, 16'sd0);
        // Just below the range.
        send_request(KIND_POINT, -16'sd1, 16'sd0);
        send_request(KIND_FINISH, 16'sh8000, 16'sh7FFF);
        wait_for_idle();

        // Same left ratio in the two-ended mode fails without a right match.
        write_register(rpbc_pkg::REG_HARD_MODE, 32'd1);
        send_request(KIND_POINT, 16'sd0, 16'sd0);
        send_request(KIND_POINT, 16'sd26, 16'sd0);
        send_request(KIND_POINT, 16'sd27, 16'sd0);
        send_request(KIND_FINISH, 16'sd0, 16'sd0);
        wait_for_idle();
    endtask

    // Register values at their limits, each followed by a short noise set.
    task automatic test_register_extremes();
        rpbc_pkg::cfg_t c;
        for (int i = 0; i < 6; i++) begin
            c.cos_coef  = (i % 3 == 0) ? 16'sh8000 : (i % 3 == 1) ? 16'sh7FFF : 16'sh0000;
            c.sin_coef  = (i % 2 == 0) ? 16'sh7FFF : 16'sh8000;
            c.min_x     = (i < 2) ? 32'h8000_0000 : (i < 4) ? 32'h7FFF_FFFF : 32'h0000_0000;
            c.bin_scale = (i % 2 == 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
            c.hard_mode = i[0];
            program_config(c);
            send_noise_set(12);
            wait_for_idle();
        end
    endtask

    // Mostly shaped sets, some noise, with a fresh setting every few sets.
    task automatic test_random_sets(int item_budget);
        int stop_at;
        int sets;
        stop_at = points_sent + finishes_sent + item_budget;
        sets = 0;
        while (points_sent + finishes_sent < stop_at) begin
            if (sets % 8 == 0) begin
                wait_for_idle();
                program_config(spread_config());
            end
            if ($urandom_range(0, 3) == 0)
                send_noise_set(20);
            else
                send_shaped_set();
            sets++;
        end
        wait_for_idle();
    endtask

    // The result side holds off for a long stretch while finish requests
    // keep coming, so the block must fill up and stall its input.
    task automatic test_output_hold();
        hold_requests++;
        repeat (40) begin
            if ($urandom_range(0, 2) == 0)
                send_request(KIND_POINT, 16'($urandom), 16'($urandom));
            send_request(KIND_FINISH, 16'($urandom), 16'($urandom));
        end
        wait_for_idle();
    endtask

    // ------------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------------
    initial begin
        model_cfg.cos_coef  = rpbc_pkg::COS_COEF_RST;
        model_cfg.sin_coef  = '0;
        model_cfg.min_x     = '0;
        model_cfg.bin_scale = '0;
        model_cfg.hard_mode = 1'b0;
        clear_histogram();

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender idles lightly, receiver stalls heavily.
        send_idle_pct  = 18;
        recv_stall_pct = 72;
        test_directed_cases();
        test_register_extremes();
        test_random_sets(460);

        // The other way round, plus the long hold-off.
        send_idle_pct  = 72;
        recv_stall_pct = 18;
        test_output_hold();
        test_random_sets(420);

        // Back to back on both sides.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_sets(420);

        $display("Sent %0d point and %0d finish requests over directed, extreme, shaped",
                 points_sent, finishes_sent);
        $display("and hold-off tests; %0d decisions checked (%0d match, %0d drop).",
                 decisions_checked, matches_seen, drops_seen);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #600000;
        $display("FAIL");
        $finish;
    end

endmodule
